// ===== hw/rtl/median_and_weighted_sum_3x3_assert.svh =====
// Assertion macros shared by the filter RTL.
`ifndef MEDIAN_AND_WEIGHTED_SUM_3X3_ASSERT_SVH
`define MEDIAN_AND_WEIGHTED_SUM_3X3_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define MWS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mws_pkg.sv =====
// Shared widths and constants of the 3x3 median and weighted sum filter.
`default_nettype none

package mws_pkg;

  // Rows per image column.
  localparam int NROWS = 3;

  // Field widths on the channels.
  localparam int IN_PIX_BITS = 8;
  localparam int MED_BITS    = 8;
  localparam int SUM_BITS    = 12;

endpackage

`default_nettype wire

// ===== hw/rtl/mws_if.sv =====
// Valid/ready channel interfaces for column items and result items.
`default_nettype none

interface mws_in_if;
  import mws_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [IN_PIX_BITS-1:0] med_top;
  logic [IN_PIX_BITS-1:0] med_middle;
  logic [IN_PIX_BITS-1:0] med_bottom;
  logic [IN_PIX_BITS-1:0] avg_top;
  logic [IN_PIX_BITS-1:0] avg_middle;
  logic [IN_PIX_BITS-1:0] avg_bottom;
  logic                   want_median;
  logic                   want_sum;

  modport source (
    output valid, med_top, med_middle, med_bottom,
    output avg_top, avg_middle, avg_bottom, want_median, want_sum,
    input  ready
  );

  modport sink (
    input  valid, med_top, med_middle, med_bottom,
    input  avg_top, avg_middle, avg_bottom, want_median, want_sum,
    output ready
  );
endinterface

interface mws_out_if;
  import mws_pkg::*;

  logic                valid;
  logic                ready;
  logic [MED_BITS-1:0] median_value;
  logic                median_ok;
  logic [SUM_BITS-1:0] weighted_sum;
  logic                sum_ok;

  modport source (
    output valid, median_value, median_ok, weighted_sum, sum_ok,
    input  ready
  );

  modport sink (
    input  valid, median_value, median_ok, weighted_sum, sum_ok,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/mws_lane.sv =====
// One column lane: sorts its three median pixels and sums its sum pixels.
`default_nettype none

module mws_lane #(
  parameter int W          = 8,
  parameter bit DOUBLE_MID = 1'b0
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] med_col [mws_pkg::NROWS],
  input  logic [W-1:0] sum_col [mws_pkg::NROWS],
  output logic [W-1:0] lo_r,
  output logic [W-1:0] mid_r,
  output logic [W-1:0] hi_r,
  output logic [W+1:0] csum_r
);
  import mws_pkg::*;

  logic [W-1:0] a, b, c, t;
  logic [W-1:0] lo_nxt, mid_nxt, hi_nxt;
  logic [W+1:0] csum_nxt;

  // Three compare-exchange steps sort the column.
  always_comb begin
    t = '0;
    a = med_col[0];
    b = med_col[1];
    c = med_col[2];
    if (a > b) begin
      t = a; a = b; b = t;
    end
    if (b > c) begin
      t = b; b = c; c = t;
    end
    if (a > b) begin
      t = a; a = b; b = t;
    end
    lo_nxt  = a;
    mid_nxt = b;
    hi_nxt  = c;
  end

  // Column sum; the center lane counts its middle row twice.
  always_comb begin
    csum_nxt = '0;
    for (int r = 0; r < NROWS; r++) begin
      csum_nxt = csum_nxt + (W+2)'(sum_col[r]);
    end
    if (DOUBLE_MID) begin
      csum_nxt = csum_nxt + (W+2)'(sum_col[1]);
    end
  end

  // Lane stage register.
  always_ff @(posedge clk) begin
    if (en) begin
      lo_r   <= lo_nxt;
      mid_r  <= mid_nxt;
      hi_r   <= hi_nxt;
      csum_r <= csum_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mws_merge.sv =====
// Merges the lane results into the median of nine and the weighted sum.
`default_nettype none

module mws_merge #(
  parameter int W = 8
) (
  input  logic         want_median,
  input  logic         want_sum,
  input  logic [W-1:0] lo   [mws_pkg::NROWS],
  input  logic [W-1:0] mid  [mws_pkg::NROWS],
  input  logic [W-1:0] hi   [mws_pkg::NROWS],
  input  logic [W+1:0] csum [mws_pkg::NROWS],
  output logic [W-1:0] median,
  output logic [W+3:0] wsum
);
  import mws_pkg::*;

  function automatic logic [W-1:0] max3(input logic [W-1:0] x, y, z);
    logic [W-1:0] m;
    m = (x > y) ? x : y;
    return (m > z) ? m : z;
  endfunction

  function automatic logic [W-1:0] min3(input logic [W-1:0] x, y, z);
    logic [W-1:0] m;
    m = (x < y) ? x : y;
    return (m < z) ? m : z;
  endfunction

  function automatic logic [W-1:0] med3(input logic [W-1:0] x, y, z);
    logic [W-1:0] lo_xy, hi_xy;
    lo_xy = (x < y) ? x : y;
    hi_xy = (x < y) ? y : x;
    if (z <= lo_xy) return lo_xy;
    if (z >= hi_xy) return hi_xy;
    return z;
  endfunction

  logic [W-1:0] max_lo, med_mid, min_hi;
  logic [W+3:0] total;

  // Median of nine from sorted columns: max of lows, median of mids, min of highs.
  always_comb begin
    max_lo  = max3(lo[0], lo[1], lo[2]);
    med_mid = med3(mid[0], mid[1], mid[2]);
    min_hi  = min3(hi[0], hi[1], hi[2]);
    median  = want_median ? med3(max_lo, med_mid, min_hi) : '0;
  end

  // Add the three column sums.
  always_comb begin
    total = '0;
    for (int i = 0; i < NROWS; i++) begin
      total = total + (W+4)'(csum[i]);
    end
    wsum = want_sum ? total : '0;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/median_and_weighted_sum_3x3.sv =====
// Top level of the sliding 3x3 median and weighted sum filter.
`default_nettype none

// Each input item is one new three-row image column carrying a median pixel
// and a sum pixel per row. The block takes one item per clock cycle while
// in_ch.ready is high and returns exactly one result item per input item, in
// order; a result passes through one register in each column lane, then the
// output register after the merge stage. in_ch.ready drops only when the output
// register is held by out_ch.ready and the lane stage is full. The median is
// taken over the new column and the two before it; the weighted sum is taken
// over the sum window (new column only when want_sum is set), with the middle
// row of the middle column counted twice. A result whose request bit is clear
// reads as zero. Both windows clear to zero at reset.

`include "median_and_weighted_sum_3x3_assert.svh"

module median_and_weighted_sum_3x3 #(
  parameter int PIXEL_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  mws_in_if.sink    in_ch,
  mws_out_if.source out_ch
);
  import mws_pkg::*;

  localparam int PB = PIXEL_BITS;

  // Window state: two previous median columns, three sum columns.
  logic [PB-1:0] prev1_r [NROWS];
  logic [PB-1:0] prev2_r [NROWS];
  logic [PB-1:0] sum0_r  [NROWS];
  logic [PB-1:0] sum1_r  [NROWS];
  logic [PB-1:0] sum2_r  [NROWS];

  logic [PB-1:0] new_med [NROWS];
  logic [PB-1:0] new_avg [NROWS];
  logic [PB-1:0] sum_w0  [NROWS];

  // Pipeline control.
  logic accept, take_out, adv1;
  logic s1_v_r, s1_wm_r, s1_ws_r;
  logic out_v_r;

  // Lane results and merge outputs.
  logic [PB-1:0] lane_lo   [NROWS];
  logic [PB-1:0] lane_mid  [NROWS];
  logic [PB-1:0] lane_hi   [NROWS];
  logic [PB+1:0] lane_csum [NROWS];
  logic [PB-1:0] med_nxt;
  logic [PB+3:0] sum_nxt;

  logic [MED_BITS-1:0] med_r;
  logic [SUM_BITS-1:0] sum_r;
  logic                mok_r, sok_r;

  // Input pixels at the internal width.
  always_comb begin
    new_med[0] = PB'(in_ch.med_top);
    new_med[1] = PB'(in_ch.med_middle);
    new_med[2] = PB'(in_ch.med_bottom);
    new_avg[0] = PB'(in_ch.avg_top);
    new_avg[1] = PB'(in_ch.avg_middle);
    new_avg[2] = PB'(in_ch.avg_bottom);
    for (int r = 0; r < NROWS; r++) begin
      sum_w0[r] = in_ch.want_sum ? new_avg[r] : sum0_r[r];
    end
  end

  // Handshake: the lane stage moves when empty or when the output register takes.
  assign take_out    = !out_v_r || out_ch.ready;
  assign adv1        = !s1_v_r || take_out;
  assign in_ch.ready = adv1;
  assign accept      = in_ch.valid && adv1;

  // Window shift on each accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NROWS; r++) begin
        prev1_r[r] <= '0;
        prev2_r[r] <= '0;
        sum0_r[r]  <= '0;
        sum1_r[r]  <= '0;
        sum2_r[r]  <= '0;
      end
    end else if (accept) begin
      for (int r = 0; r < NROWS; r++) begin
        prev1_r[r] <= new_med[r];
        prev2_r[r] <= prev1_r[r];
        sum0_r[r]  <= sum_w0[r];
        sum1_r[r]  <= sum_w0[r];
        sum2_r[r]  <= sum1_r[r];
      end
    end
  end

  // Column lanes: newest, middle (center weight) and oldest column.
  mws_lane #(.W(PB), .DOUBLE_MID(1'b0)) u_lane0 (
    .clk(clk), .en(accept), .med_col(new_med), .sum_col(sum_w0),
    .lo_r(lane_lo[0]), .mid_r(lane_mid[0]), .hi_r(lane_hi[0]), .csum_r(lane_csum[0])
  );

  mws_lane #(.W(PB), .DOUBLE_MID(1'b1)) u_lane1 (
    .clk(clk), .en(accept), .med_col(prev1_r), .sum_col(sum1_r),
    .lo_r(lane_lo[1]), .mid_r(lane_mid[1]), .hi_r(lane_hi[1]), .csum_r(lane_csum[1])
  );

  mws_lane #(.W(PB), .DOUBLE_MID(1'b0)) u_lane2 (
    .clk(clk), .en(accept), .med_col(prev2_r), .sum_col(sum2_r),
    .lo_r(lane_lo[2]), .mid_r(lane_mid[2]), .hi_r(lane_hi[2]), .csum_r(lane_csum[2])
  );

  // Lane stage control and request flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv1) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_wm_r <= in_ch.want_median;
      s1_ws_r <= in_ch.want_sum;
    end
  end

  // Merge stage.
  mws_merge #(.W(PB)) u_merge (
    .want_median(s1_wm_r), .want_sum(s1_ws_r),
    .lo(lane_lo), .mid(lane_mid), .hi(lane_hi), .csum(lane_csum),
    .median(med_nxt), .wsum(sum_nxt)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (take_out) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take_out && s1_v_r) begin
      med_r <= MED_BITS'(med_nxt);
      sum_r <= SUM_BITS'(sum_nxt);
      mok_r <= s1_wm_r;
      sok_r <= s1_ws_r;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.median_value = med_r;
  assign out_ch.median_ok    = mok_r;
  assign out_ch.weighted_sum = sum_r;
  assign out_ch.sum_ok       = sok_r;

  // Checks.
  `MWS_ASSERT_NOW(a_med_zero, clk, rst_n, out_v_r && !mok_r, med_r == '0,
    "median not requested but nonzero")
  `MWS_ASSERT_NOW(a_sum_zero, clk, rst_n, out_v_r && !sok_r, sum_r == '0,
    "sum not requested but nonzero")
  `MWS_ASSERT_NOW(a_no_overrun, clk, rst_n, out_v_r && !out_ch.ready && s1_v_r,
    !in_ch.ready, "item taken while pipeline is full and stalled")
  `MWS_ASSERT_NEXT(a_sum_col_hold, clk, rst_n, accept && !in_ch.want_sum,
    sum0_r[1] == $past(sum0_r[1]), "newest sum column changed without a load")

endmodule

`default_nettype wire
